/* src/ppa_pkg.sv */
// Package for the physical page allocator: payload structs, codes and
// controller/datapath command and status types. No dependencies.
package ppa_pkg;

    localparam int PAGE_COUNT_DEF = 4096;
    localparam int PAGE_SHIFT     = 12;

    localparam logic [6:0] USED_MARK = 7'd100;

    // Request opcodes
    localparam logic [1:0] OP_INIT   = 2'd0;
    localparam logic [1:0] OP_ALLOC  = 2'd1;
    localparam logic [1:0] OP_FREE   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_NONE   = 3'd1;
    localparam logic [2:0] ST_BELOW  = 3'd2;
    localparam logic [2:0] ST_BEYOND = 3'd3;
    localparam logic [2:0] ST_DOUBLE = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_BASE  = 2'd0;
    localparam logic [1:0] CFG_START = 2'd1;
    localparam logic [1:0] CFG_END   = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] free_address;
    } in_t;

    typedef struct packed {
        logic [31:0] page_address;
        logic [2:0]  status;
        logic [12:0] free_pages;
    } out_t;

    typedef struct packed {
        logic req_load;
        logic sweep_start;
        logic sweep_step;
        logic scan_start;
        logic scan_step;
        logic free_chk;
        logic free_upd;
        logic res_zero;
    } cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic scan_done;
        logic free_bad;
    } sts_t;

endpackage

/* src/ppa_dp.sv */
// Datapath of the physical page allocator: config registers, refcount RAM,
// sweep/scan index, free counter and result registers. Uses ppa_pkg.
module ppa_dp #(
    parameter int PAGE_COUNT = ppa_pkg::PAGE_COUNT_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  ppa_pkg::cmd_t  cmd,
    output ppa_pkg::sts_t  sts,
    input  ppa_pkg::in_t   s_data,
    input  logic           cfg_valid,
    input  logic [1:0]     cfg_index,
    input  logic [31:0]    cfg_data,
    output ppa_pkg::out_t  m_data
);

    localparam int IW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int CW = $clog2(PAGE_COUNT + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(PAGE_COUNT - 1);

    logic [31:0]   base_reg, start_reg, end_reg, addr_reg;
    logic [IW-1:0] idx_reg, chk_idx_reg;
    logic [19:0]   lo_reg, hi_reg;
    logic          none_reg, chk_vld_reg;
    logic [CW-1:0] cnt_reg;
    logic [6:0]    rd_data_reg;
    logic [31:0]   res_addr_reg;
    logic [2:0]    res_status_reg;
    logic [6:0]    mem [PAGE_COUNT];

    logic [31:0]   lo_addr, lo_off, hi_off, free_off;
    logic          in_rng, free_bad, scan_hit, scan_none, scan_issue;
    logic [IW-1:0] free_idx;
    logic          we, re;
    logic [IW-1:0] waddr, raddr;
    logic [6:0]    wdata;

    assign lo_addr  = (start_reg < base_reg) ? base_reg : start_reg;
    assign lo_off   = lo_addr - base_reg;
    assign hi_off   = end_reg - base_reg;
    assign in_rng   = !none_reg && (20'(idx_reg) >= lo_reg) && (20'(idx_reg) <= hi_reg);
    assign free_off = addr_reg - base_reg;
    assign free_idx = free_off[ppa_pkg::PAGE_SHIFT +: IW];
    assign free_bad = (addr_reg < base_reg) || (addr_reg >= end_reg) ||
                      (free_off[31:12] >= 20'(PAGE_COUNT));

    assign scan_hit   = chk_vld_reg && (rd_data_reg == 7'd0);
    assign scan_none  = chk_vld_reg && !scan_hit && (chk_idx_reg == '0);
    assign scan_issue = cmd.scan_step && !scan_hit && !scan_none;

    assign sts.sweep_last = (idx_reg == LAST_IDX);
    assign sts.scan_done  = scan_hit || scan_none;
    assign sts.free_bad   = free_bad;

    always_comb begin
        we    = 1'b0;
        waddr = chk_idx_reg;
        wdata = 7'd1;
        re    = 1'b0;
        raddr = idx_reg;
        if (cmd.sweep_step) begin
            we    = 1'b1;
            waddr = idx_reg;
            wdata = in_rng ? 7'd0 : ppa_pkg::USED_MARK;
        end
        if (cmd.scan_step && scan_hit) begin
            we = 1'b1;
        end
        if (cmd.free_upd && (rd_data_reg != 7'd0)) begin
            we    = 1'b1;
            wdata = rd_data_reg - 7'd1;
        end
        if (scan_issue) begin
            re = 1'b1;
        end
        if (cmd.free_chk && !free_bad) begin
            re    = 1'b1;
            raddr = free_idx;
        end
    end

    // Refcount RAM, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rd_data_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg    <= 32'h0010_0000;
            start_reg   <= '0;
            end_reg     <= '0;
            idx_reg     <= '0;
            lo_reg      <= '0;
            hi_reg      <= '1;
            none_reg    <= 1'b0;
            cnt_reg     <= '0;
            chk_vld_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    ppa_pkg::CFG_BASE:  base_reg  <= cfg_data;
                    ppa_pkg::CFG_START: start_reg <= cfg_data;
                    ppa_pkg::CFG_END:   end_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.sweep_start) begin
                idx_reg  <= '0;
                cnt_reg  <= '0;
                lo_reg   <= lo_off[31:12];
                hi_reg   <= hi_off[31:12];
                none_reg <= (end_reg < base_reg);
            end
            if (cmd.sweep_step) begin
                idx_reg <= idx_reg + 1'b1;
                if (in_rng) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            if (cmd.scan_start) begin
                idx_reg     <= LAST_IDX;
                chk_vld_reg <= 1'b0;
            end
            if (cmd.scan_step && scan_hit) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (scan_issue) begin
                chk_vld_reg <= 1'b1;
                chk_idx_reg <= idx_reg;
                idx_reg     <= idx_reg - 1'b1;
            end
            if (cmd.free_chk) begin
                chk_idx_reg <= free_idx;
            end
            if (cmd.free_upd && (rd_data_reg == 7'd1)) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.req_load) begin
            addr_reg <= s_data.free_address;
        end
        if (cmd.res_zero) begin
            res_addr_reg   <= '0;
            res_status_reg <= ppa_pkg::ST_OK;
        end
        if (cmd.scan_step && scan_hit) begin
            res_addr_reg   <= base_reg + (32'(chk_idx_reg) << ppa_pkg::PAGE_SHIFT);
            res_status_reg <= ppa_pkg::ST_OK;
        end
        if (cmd.scan_step && scan_none) begin
            res_addr_reg   <= '0;
            res_status_reg <= ppa_pkg::ST_NONE;
        end
        if (cmd.free_chk && free_bad) begin
            res_addr_reg   <= '0;
            res_status_reg <= (addr_reg < base_reg) ? ppa_pkg::ST_BELOW : ppa_pkg::ST_BEYOND;
        end
        if (cmd.free_upd) begin
            res_addr_reg   <= '0;
            res_status_reg <= (rd_data_reg == 7'd0) ? ppa_pkg::ST_DOUBLE : ppa_pkg::ST_OK;
        end
    end

    assign m_data.page_address = res_addr_reg;
    assign m_data.status       = res_status_reg;
    assign m_data.free_pages   = 13'(cnt_reg);

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(PAGE_COUNT))
        else $error("free counter above page count");
    a_hit_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.scan_step && scan_hit) |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("alloc hit did not take a free page");
    a_double: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.free_upd && rd_data_reg == 7'd0) |=> (res_status_reg == ppa_pkg::ST_DOUBLE))
        else $error("free of free page not flagged");
`endif

endmodule

/* src/ppa_ctrl.sv */
// Controller of the physical page allocator: request sequencing and the
// result valid flag. Uses ppa_pkg command/status types.
module ppa_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [1:0]    opcode,
    output logic          m_valid,
    input  logic          m_ready,
    output ppa_pkg::cmd_t cmd,
    input  ppa_pkg::sts_t sts
);

    localparam logic [2:0] ST_CLR     = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_INIT    = 3'd2;
    localparam logic [2:0] ST_ALLOC   = 3'd3;
    localparam logic [2:0] ST_FREE_RD = 3'd4;
    localparam logic [2:0] ST_FREE_WR = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_vld_reg, out_vld_next;

    assign s_ready = (state_reg == ST_IDLE) && (!out_vld_reg || m_ready);
    assign m_valid = out_vld_reg;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        out_vld_next = out_vld_reg && !m_ready;
        case (state_reg)
            ST_CLR: begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.req_load = 1'b1;
                    case (opcode)
                        ppa_pkg::OP_INIT: begin
                            cmd.sweep_start = 1'b1;
                            state_next      = ST_INIT;
                        end
                        ppa_pkg::OP_ALLOC: begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_ALLOC;
                        end
                        ppa_pkg::OP_FREE: begin
                            state_next = ST_FREE_RD;
                        end
                        default: begin
                            cmd.res_zero = 1'b1;
                            out_vld_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_INIT: begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last) begin
                    cmd.res_zero = 1'b1;
                    out_vld_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_ALLOC: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done) begin
                    out_vld_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_FREE_RD: begin
                cmd.free_chk = 1'b1;
                if (sts.free_bad) begin
                    out_vld_next = 1'b1;
                    state_next   = ST_IDLE;
                end else begin
                    state_next = ST_FREE_WR;
                end
            end
            ST_FREE_WR: begin
                cmd.free_upd = 1'b1;
                out_vld_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_nop_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && opcode != ppa_pkg::OP_INIT && opcode != ppa_pkg::OP_ALLOC &&
         opcode != ppa_pkg::OP_FREE) |=> out_vld_reg)
        else $error("no result for unused opcode");
    a_free_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FREE_WR) |=> (state_reg == ST_IDLE && out_vld_reg))
        else $error("free update did not finish");
    a_init_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INIT && sts.sweep_last) |=> out_vld_reg)
        else $error("init sweep ended without result");
`endif

endmodule

/* src/physical_page_allocator.sv */
// Top level of the physical page allocator: refcount map with init, alloc
// and free requests. Instantiates ppa_ctrl and ppa_dp; uses ppa_pkg.
//
//   port group  dir  handshake          payload
//   s_*         in   s_valid/s_ready    s_data   (opcode, free_address)
//   m_*         out  m_valid/m_ready    m_data   (page_address, status, free_pages)
//   cfg_*       in   cfg_valid/ready    cfg_index, cfg_data
//
// Init sweeps the refcount RAM one page a cycle.
// Alloc scans the RAM downward from the top page through its registered read
// port. Free checks the address, reads the page's count and then updates it.
// Reset: a clearing pass zeroes the RAM; no request is taken until it ends.
// Config writes are always taken.
// Stalls: one request in flight; a new request is taken once the result
// register is empty or being drained.
module physical_page_allocator #(
    parameter int PAGE_COUNT = ppa_pkg::PAGE_COUNT_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  ppa_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output ppa_pkg::out_t m_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data
);

    ppa_pkg::cmd_t cmd;
    ppa_pkg::sts_t sts;

    // Registers are plain flops, writable every cycle
    assign cfg_ready = 1'b1;

    ppa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .opcode  (s_data.opcode),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    ppa_dp #(
        .PAGE_COUNT (PAGE_COUNT)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_data    (m_data)
    );

endmodule

/* bench/tb_top.sv */
// Testbench for physical_page_allocator: directed and random init, alloc and
// free requests checked against a behavioral refcount map. Uses ppa_pkg.
`timescale 1ns / 1ps

module tb_top;

    localparam int PAGES = ppa_pkg::PAGE_COUNT_DEF;
    localparam int HOLD_CYCLES = 3 * PAGES;

    logic  aclk = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    ppa_pkg::in_t   s_data = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    ppa_pkg::out_t  m_data;
    logic  cfg_valid = 1'b0;
    logic  cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    always #5 aclk = ~aclk;

    physical_page_allocator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Behavioral copy of the map and registers
    logic [6:0]  refcnt [PAGES];
    int unsigned nfree;
    logic [31:0] base_reg, start_reg, end_reg;

    ppa_pkg::out_t expected_q[$];
    int   errors = 0;
    int   n_req = 0;
    int   n_res = 0;
    int   rx_wait = 0;          // receiver idle cycles left for this result
    bit   hold_off = 1'b0;      // receiver long stall
    logic [31:0] alloc_pool[$]; // addresses handed out, reused by frees

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("ERROR t=%0t result %0d %s got %0h want %0h",
                 $realtime, n_res, what, got, want);
        errors++;
    endtask

    function automatic ppa_pkg::out_t predict_page_op(input ppa_pkg::in_t rq);
        ppa_pkg::out_t r;
        logic [31:0] lo, idx;
        longint first, last;
        r = '0;
        case (rq.opcode)
            ppa_pkg::OP_INIT: begin
                for (int i = 0; i < PAGES; i++) refcnt[i] = ppa_pkg::USED_MARK;
                nfree = 0;
                lo = (start_reg < base_reg) ? base_reg : start_reg;
                if (end_reg >= base_reg) begin
                    first = (lo - base_reg) >> ppa_pkg::PAGE_SHIFT;
                    last = (end_reg - base_reg) >> ppa_pkg::PAGE_SHIFT;
                    if (last >= PAGES) last = PAGES - 1;
                    for (longint i = first; i <= last; i++) begin
                        refcnt[i] = '0;
                        nfree++;
                    end
                end
            end
            ppa_pkg::OP_ALLOC: begin
                r.status = ppa_pkg::ST_NONE;
                for (int i = PAGES - 1; i >= 0; i--) begin
                    if (refcnt[i] == 0) begin
                        refcnt[i] = 7'd1;
                        nfree--;
                        r.status = ppa_pkg::ST_OK;
                        r.page_address = base_reg + (32'(i) << ppa_pkg::PAGE_SHIFT);
                        alloc_pool.push_back(r.page_address);
                        break;
                    end
                end
            end
            ppa_pkg::OP_FREE: begin
                idx = (rq.free_address - base_reg) >> ppa_pkg::PAGE_SHIFT;
                if (rq.free_address < base_reg) r.status = ppa_pkg::ST_BELOW;
                else if (rq.free_address >= end_reg || idx >= PAGES)
                    r.status = ppa_pkg::ST_BEYOND;
                else if (refcnt[idx] == 0) r.status = ppa_pkg::ST_DOUBLE;
                else begin
                    refcnt[idx] = refcnt[idx] - 7'd1;
                    if (refcnt[idx] == 0) nfree++;
                end
            end
            default: ;
        endcase
        r.free_pages = 13'(nfree);
        return r;
    endfunction

    // Send one request, then a random idle gap; with no gap valid stays up
    // for the next request
    task automatic send_request(input logic [1:0] op, input logic [31:0] addr);
        ppa_pkg::in_t rq;
        int gap;
        rq.opcode = op;
        rq.free_address = addr;
        s_valid <= 1'b1;
        s_data <= rq;
        do @(posedge aclk); while (!s_ready);
        expected_q.push_back(predict_page_op(rq));
        n_req++;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Wait until every expected result is back, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            ppa_pkg::CFG_BASE:  base_reg = val;
            ppa_pkg::CFG_START: start_reg = val;
            default:            end_reg = val;
        endcase
    endtask

    task automatic set_window(input logic [31:0] b, input logic [31:0] s,
                              input logic [31:0] e);
        drain();
        write_reg(ppa_pkg::CFG_BASE, b);
        write_reg(ppa_pkg::CFG_START, s);
        write_reg(ppa_pkg::CFG_END, e);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: random wait per result, plus a long hold-off while hold_off is set
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_res++;
                rx_wait = $urandom_range(0, 10);
                if (expected_q.size() == 0) begin
                    $display("ERROR t=%0t unexpected result %0h", $realtime, m_data);
                    errors++;
                end else begin
                    ppa_pkg::out_t w;
                    w = expected_q.pop_front();
                    if (m_data.page_address !== w.page_address)
                        report("page_address", m_data.page_address, w.page_address);
                    if (m_data.status !== w.status)
                        report("status", 32'(m_data.status), 32'(w.status));
                    if (m_data.free_pages !== w.free_pages)
                        report("free_pages", 32'(m_data.free_pages), 32'(w.free_pages));
                end
            end else if (rx_wait != 0 && !hold_off) begin
                rx_wait--;
            end
            m_ready <= !hold_off && (rx_wait == 0);
        end
    end

    task automatic test_reset_state();
        // Map is all free after reset, default window
        send_request(ppa_pkg::OP_ALLOC, '0);
        send_request(ppa_pkg::OP_FREE, 32'h0010_0000);
        send_request(ppa_pkg::OP_FREE, 32'h0);
        send_request(ppa_pkg::OP_UNUSED, 32'hFFFF_FFFF);
    endtask

    task automatic test_directed();
        // Small window: 4 pages free, alloc past exhaustion
        set_window(32'h0010_0000, 32'h0, 32'h0010_3000);
        send_request(ppa_pkg::OP_INIT, '0);
        repeat (5) send_request(ppa_pkg::OP_ALLOC, '0);
        send_request(ppa_pkg::OP_FREE, 32'h0010_3FFF);       // beyond end
        send_request(ppa_pkg::OP_FREE, 32'h000F_FFFF);       // below base
        send_request(ppa_pkg::OP_FREE, 32'h0010_2ABC);       // ok, page freed
        send_request(ppa_pkg::OP_FREE, 32'h0010_2000);       // freeing a free page
        send_request(ppa_pkg::OP_FREE, 32'h0010_0000);       // used page 0
        // End below base: nothing freed
        set_window(32'h8000_0000, 32'h0, 32'h7FFF_FFFF);
        send_request(ppa_pkg::OP_INIT, '0);
        send_request(ppa_pkg::OP_ALLOC, '0);
        send_request(ppa_pkg::OP_FREE, 32'h8000_0000);
        // Extremes: whole address space, index clipping, wrapping addresses
        set_window(32'hFFFF_F000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(ppa_pkg::OP_INIT, '0);
        send_request(ppa_pkg::OP_ALLOC, '0);
        send_request(ppa_pkg::OP_FREE, 32'hFFFF_FFFF);
        set_window(32'h0, 32'h0, 32'hFFFF_FFFF);
        send_request(ppa_pkg::OP_INIT, '0);
        send_request(ppa_pkg::OP_ALLOC, '0);
        send_request(ppa_pkg::OP_FREE, 32'h00FF_F000);
        send_request(ppa_pkg::OP_FREE, 32'h0100_0000);       // index past the map
        send_request(ppa_pkg::OP_UNUSED, '0);
    endtask

    // Random window, then mostly allocs and frees of handed-out pages
    task automatic test_random(input int n);
        logic [31:0] b, addr;
        int pick;
        b = $urandom_range(0, 3) == 0 ? $urandom() : ($urandom() & 32'hFFFF_F000);
        set_window(b,
                   b + ($urandom_range(0, 40) << ppa_pkg::PAGE_SHIFT) - $urandom_range(0, 8192),
                   b + ($urandom_range(0, 80) << ppa_pkg::PAGE_SHIFT) + $urandom_range(0, 4095));
        alloc_pool.delete();
        send_request(ppa_pkg::OP_INIT, '0);
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) send_request(ppa_pkg::OP_ALLOC, $urandom());
            else if (pick < 85 && alloc_pool.size() != 0) begin
                addr = alloc_pool[$urandom_range(0, alloc_pool.size() - 1)];
                send_request(ppa_pkg::OP_FREE, addr | $urandom_range(0, 4095));
            end else if (pick < 97) send_request(ppa_pkg::OP_FREE, $urandom());
            else send_request($urandom_range(0, 1) ? ppa_pkg::OP_INIT : ppa_pkg::OP_UNUSED,
                              $urandom());
        end
    endtask

    task automatic test_backpressure();
        set_window(32'h0020_0000, 32'h0020_0000, 32'h0020_8000);
        send_request(ppa_pkg::OP_INIT, '0);
        fork
            begin
                hold_off = 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off = 1'b0;
            end
            repeat (6) send_request(ppa_pkg::OP_ALLOC, '0);
        join
        drain();    // sender pause until all results are in
        repeat (6) send_request(ppa_pkg::OP_FREE,
                                32'h0020_8000 - ($urandom_range(0, 8) << ppa_pkg::PAGE_SHIFT));
    endtask

    initial begin
        base_reg = 32'h0010_0000;
        start_reg = '0;
        end_reg = '0;
        for (int i = 0; i < PAGES; i++) refcnt[i] = '0;
        nfree = PAGES;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_state();
        test_directed();
        test_backpressure();
        for (int p = 0; p < 24; p++) test_random(80);
        drain();
        $display("Covered %0d requests, %0d results: init, alloc, free, all status codes,",
                 n_req, n_res);
        $display("windows at address extremes and long result-side stalls.");
        if (errors == 0 && expected_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #1s;
        $display("Mismatches found");
        $finish;
    end
endmodule

/* files.f */
src/ppa_pkg.sv
src/ppa_dp.sv
src/ppa_ctrl.sv
src/physical_page_allocator.sv
bench/tb_top.sv
